FILE: rtl/core/rbc_pkg.sv
// ----------------------------------------------------------------------------
// rbc_pkg
// Shared types, register indexes and reset constants for the response button
// controller.
// ----------------------------------------------------------------------------
package rbc_pkg;

    localparam int unsigned CFG_COUNT   = 5;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 8;
    localparam int unsigned QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_TICKS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_BEEP_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_BEEP_TICKS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RING_TOGGLES     = 3'd4;

    // Configuration reset values.
    localparam logic [7:0] RST_TICKS_PER_SECOND = 8'd100;
    localparam logic [7:0] RST_LOCKOUT_TICKS    = 8'd120;
    localparam logic [7:0] RST_SHORT_BEEP_TICKS = 8'd20;
    localparam logic [7:0] RST_LONG_BEEP_TICKS  = 8'd100;
    localparam logic [7:0] RST_RING_TOGGLES     = 8'd40;

    // Beep length used for each half period of the ring pattern.
    localparam logic [7:0] RING_STEP_TICKS = 8'd2;

    // Input modes.
    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_PRESS   = 2'd1;
    localparam logic [1:0] MODE_COMMAND = 2'd2;

    // Command codes.
    localparam logic [3:0] CMD_START   = 4'h1;
    localparam logic [3:0] CMD_CANCEL  = 4'h2;
    localparam logic [3:0] CMD_VOLTAGE = 4'h4;
    localparam logic [3:0] CMD_SOUND   = 4'h5;
    localparam logic [3:0] CMD_TIMEOUT = 4'h6;

    // Sound mode parameters.
    localparam logic [7:0] SOUND_OFF   = 8'd0;
    localparam logic [7:0] SOUND_SHORT = 8'd1;
    localparam logic [7:0] SOUND_LONG  = 8'd2;
    localparam logic [7:0] SOUND_RING  = 8'd3;

    // Reply kinds.
    localparam logic REPLY_STAMP   = 1'b0;
    localparam logic REPLY_VOLTAGE = 1'b1;

    // Operation decoded by the front end.
    typedef enum logic [3:0] {
        OP_NOP         = 4'd0,
        OP_TICK        = 4'd1,
        OP_PRESS       = 4'd2,
        OP_START       = 4'd3,
        OP_CANCEL      = 4'd4,
        OP_VOLTAGE     = 4'd5,
        OP_SOUND_OFF   = 4'd6,
        OP_SOUND_SHORT = 4'd7,
        OP_SOUND_LONG  = 4'd8,
        OP_SOUND_RING  = 4'd9,
        OP_TIMEOUT     = 4'd10
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic       button_up;
        logic [7:0] battery_sample;
    } op_t;

    typedef struct packed {
        logic [7:0] ticks_per_second;
        logic [7:0] lockout_ticks;
        logic [7:0] short_beep_ticks;
        logic [7:0] long_beep_ticks;
        logic [7:0] ring_toggles;
    } cfg_t;

endpackage

FILE: rtl/core/rbc_front.sv
// ----------------------------------------------------------------------------
// rbc_front
// Input handshake and item decoder: turns mode, command code and parameter
// into one operation for the execution stage.
// ----------------------------------------------------------------------------
module rbc_front
    import rbc_pkg::*;
(
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] mode,
    input  logic       button_up,
    input  logic [7:0] battery_sample,
    input  logic [3:0] command_code,
    input  logic [7:0] command_param,
    input  logic       q_full,
    output logic       push,
    output op_t        push_op
);

    op_kind_t kind;

    always_comb
    begin
        kind = OP_NOP;
        case (mode)
            MODE_TICK:  kind = OP_TICK;
            MODE_PRESS: kind = OP_PRESS;
            MODE_COMMAND:
            begin
                case (command_code)
                    CMD_START:   kind = OP_START;
                    CMD_CANCEL:  kind = OP_CANCEL;
                    CMD_VOLTAGE: kind = OP_VOLTAGE;
                    CMD_TIMEOUT: kind = OP_TIMEOUT;
                    CMD_SOUND:
                    begin
                        case (command_param)
                            SOUND_OFF:   kind = OP_SOUND_OFF;
                            SOUND_SHORT: kind = OP_SOUND_SHORT;
                            SOUND_LONG:  kind = OP_SOUND_LONG;
                            SOUND_RING:  kind = OP_SOUND_RING;
                            default:     kind = OP_NOP;
                        endcase
                    end
                    default: kind = OP_NOP;
                endcase
            end
            default: kind = OP_NOP;
        endcase
    end

    assign in_ready               = !q_full;
    assign push                   = in_valid && !q_full;
    assign push_op.kind           = kind;
    assign push_op.button_up      = button_up;
    assign push_op.battery_sample = battery_sample;

endmodule

FILE: rtl/core/rbc_queue.sv
// ----------------------------------------------------------------------------
// rbc_queue
// Short operation queue between the decoder and the execution stage.
// ----------------------------------------------------------------------------
module rbc_queue
    import rbc_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    input  logic pop,
    output logic q_valid,
    output op_t  head_op
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    op_t              slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full    = (count_reg == FULL_CNT);
    assign q_valid = (count_reg != '0);
    assign head_op = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

FILE: rtl/core/rbc_back.sv
// ----------------------------------------------------------------------------
// rbc_back
// Execution stage: holds the timer, lockout, beeper and battery state, applies
// one operation per cycle unless its output stalls, and registers the result.
// ----------------------------------------------------------------------------
module rbc_back
    import rbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_valid,
    input  op_t         head_op,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        reply_valid,
    output logic        reply_kind,
    output logic [15:0] reply_value,
    output logic        beeper_on,
    output logic        round_running
);

    logic [15:0] round_timer_reg,    round_timer_next;
    logic        press_armed_reg,    press_armed_next;
    logic        running_reg,        running_next;
    logic [7:0]  lockout_left_reg,   lockout_left_next;
    logic [7:0]  beep_left_reg,      beep_left_next;
    logic [7:0]  ring_left_reg,      ring_left_next;
    logic [7:0]  second_div_reg,     second_div_next;
    logic [15:0] battery_sum_reg,    battery_sum_next;
    logic [7:0]  battery_level_reg,  battery_level_next;
    logic        beeper_reg,         beeper_next;

    logic        out_valid_reg;
    logic        res_valid_reg,      res_valid_next;
    logic        res_kind_reg,       res_kind_next;
    logic [15:0] res_value_reg,      res_value_next;
    logic        res_beeper_reg;
    logic        res_running_reg;

    // Running average: sum * 63 / 64 plus the new sample, rounded to 8 bits.
    logic [21:0] sum_x63;
    logic [16:0] avg_sum;
    logic [16:0] avg_round;

    assign sum_x63   = {battery_sum_reg, 6'b0} - {6'b0, battery_sum_reg};
    assign avg_sum   = {1'b0, sum_x63[21:6]} + {9'b0, head_op.battery_sample};
    assign avg_round = avg_sum + 17'd32;

    assign pop = q_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        round_timer_next   = round_timer_reg;
        press_armed_next   = press_armed_reg;
        running_next       = running_reg;
        lockout_left_next  = lockout_left_reg;
        beep_left_next     = beep_left_reg;
        ring_left_next     = ring_left_reg;
        second_div_next    = second_div_reg;
        battery_sum_next   = battery_sum_reg;
        battery_level_next = battery_level_reg;
        beeper_next        = beeper_reg;
        res_valid_next     = 1'b0;
        res_kind_next      = REPLY_STAMP;
        res_value_next     = '0;

        case (head_op.kind)
            OP_TICK:
            begin
                round_timer_next = round_timer_reg + 16'd1;
                if (head_op.button_up && (lockout_left_reg != '0))
                begin
                    if (lockout_left_reg == 8'd1)
                    begin
                        press_armed_next  = 1'b1;
                        lockout_left_next = '0;
                    end
                    else
                    begin
                        lockout_left_next = lockout_left_reg - 8'd1;
                    end
                end
                if (beep_left_reg != '0)
                begin
                    beep_left_next = beep_left_reg - 8'd1;
                end
                else if (ring_left_reg != '0)
                begin
                    beep_left_next = RING_STEP_TICKS;
                    beeper_next    = ring_left_reg[0];
                    ring_left_next = ring_left_reg - 8'd1;
                end
                else
                begin
                    beeper_next = 1'b0;
                end
                if (second_div_reg != '0)
                begin
                    second_div_next = second_div_reg - 8'd1;
                end
                else
                begin
                    battery_sum_next   = avg_sum[15:0];
                    battery_level_next = avg_round[13:6];
                    second_div_next    = cfg.ticks_per_second;
                end
            end
            OP_PRESS:
            begin
                if (press_armed_reg)
                begin
                    press_armed_next  = 1'b0;
                    lockout_left_next = cfg.lockout_ticks;
                    beeper_next       = 1'b1;
                    beep_left_next    = cfg.short_beep_ticks;
                    running_next      = 1'b1;
                    res_valid_next    = 1'b1;
                    res_kind_next     = REPLY_STAMP;
                    // A press outside a round opens one and stamps zero.
                    if (running_reg)
                    begin
                        res_value_next = round_timer_reg;
                    end
                    else
                    begin
                        round_timer_next = '0;
                    end
                end
            end
            OP_START:
            begin
                running_next     = 1'b0;
                press_armed_next = 1'b1;
                beeper_next      = 1'b1;
                beep_left_next   = cfg.long_beep_ticks;
            end
            OP_CANCEL:
            begin
                running_next     = 1'b0;
                press_armed_next = 1'b0;
            end
            OP_VOLTAGE:
            begin
                res_valid_next = 1'b1;
                res_kind_next  = REPLY_VOLTAGE;
                res_value_next = {8'd0, battery_level_reg};
            end
            OP_SOUND_OFF:
            begin
                beeper_next = 1'b0;
            end
            OP_SOUND_SHORT:
            begin
                beeper_next    = 1'b1;
                beep_left_next = cfg.short_beep_ticks;
            end
            OP_SOUND_LONG:
            begin
                beeper_next    = 1'b1;
                beep_left_next = cfg.long_beep_ticks;
            end
            OP_SOUND_RING:
            begin
                beeper_next    = 1'b1;
                beep_left_next = RING_STEP_TICKS;
                ring_left_next = cfg.ring_toggles;
            end
            OP_TIMEOUT:
            begin
                running_next     = 1'b1;
                round_timer_next = '0;
                beeper_next      = 1'b1;
                beep_left_next   = cfg.long_beep_ticks;
            end
            default:
            begin
                res_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_timer_reg   <= '0;
            press_armed_reg   <= 1'b1;
            running_reg       <= 1'b0;
            lockout_left_reg  <= '0;
            beep_left_reg     <= RST_SHORT_BEEP_TICKS;
            ring_left_reg     <= '0;
            second_div_reg    <= '0;
            battery_sum_reg   <= '0;
            battery_level_reg <= '0;
            beeper_reg        <= 1'b1;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                round_timer_reg   <= round_timer_next;
                press_armed_reg   <= press_armed_next;
                running_reg       <= running_next;
                lockout_left_reg  <= lockout_left_next;
                beep_left_reg     <= beep_left_next;
                ring_left_reg     <= ring_left_next;
                second_div_reg    <= second_div_next;
                battery_sum_reg   <= battery_sum_next;
                battery_level_reg <= battery_level_next;
                beeper_reg        <= beeper_next;
                out_valid_reg     <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_valid_reg   <= res_valid_next;
            res_kind_reg    <= res_kind_next;
            res_value_reg   <= res_value_next;
            res_beeper_reg  <= beeper_next;
            res_running_reg <= running_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign reply_valid   = res_valid_reg;
    assign reply_kind    = res_kind_reg;
    assign reply_value   = res_value_reg;
    assign beeper_on     = res_beeper_reg;
    assign round_running = res_running_reg;

endmodule

FILE: rtl/core/response_button_controller.sv
// ----------------------------------------------------------------------------
// response_button_controller
// Timing and beeper controller for a wireless response button.
// ----------------------------------------------------------------------------
// With the queue empty, an accepted item is captured in the queue register and
// then executed into the output register once that is free, and offered there.
// Throughput: one item per cycle while the output is not stalled, set by the
// execution stage that updates all state and loads the output register together.
// Reset (rst_n low, asynchronous): registers take their documented defaults,
// the queue and output register empty, the beeper starts a short beep.
// ----------------------------------------------------------------------------
module response_button_controller
    import rbc_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Configuration write port.
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // Input items.
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            mode,
    input  logic                  button_up,
    input  logic [7:0]            battery_sample,
    input  logic [3:0]            command_code,
    input  logic [7:0]            command_param,

    // Result items, exactly one for every input transfer.
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  reply_valid,
    output logic                  reply_kind,
    output logic [15:0]           reply_value,
    output logic                  beeper_on,
    output logic                  round_running
);

    // Configuration registers. The user must write them only while the block
    // is idle (not enforced); the execution stage reads them directly.
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_second <= RST_TICKS_PER_SECOND;
            cfg_reg.lockout_ticks    <= RST_LOCKOUT_TICKS;
            cfg_reg.short_beep_ticks <= RST_SHORT_BEEP_TICKS;
            cfg_reg.long_beep_ticks  <= RST_LONG_BEEP_TICKS;
            cfg_reg.ring_toggles     <= RST_RING_TOGGLES;
        end
        else if (cfg_we)
        begin
            // A write to an index beyond the register list is dropped.
            case (cfg_index)
                REG_TICKS_PER_SECOND: cfg_reg.ticks_per_second <= cfg_data;
                REG_LOCKOUT_TICKS:    cfg_reg.lockout_ticks    <= cfg_data;
                REG_SHORT_BEEP_TICKS: cfg_reg.short_beep_ticks <= cfg_data;
                REG_LONG_BEEP_TICKS:  cfg_reg.long_beep_ticks  <= cfg_data;
                REG_RING_TOGGLES:     cfg_reg.ring_toggles     <= cfg_data;
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    // The front end decodes each item into an operation and pushes it into
    // the queue whenever the queue has room, independent of the output side.
    logic q_full;
    logic push;
    op_t  push_op;
    logic pop;
    logic q_valid;
    op_t  head_op;

    rbc_front u_front (
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .button_up      (button_up),
        .battery_sample (battery_sample),
        .command_code   (command_code),
        .command_param  (command_param),
        .q_full         (q_full),
        .push           (push),
        .push_op        (push_op)
    );

    rbc_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (pop),
        .q_valid (q_valid),
        .head_op (head_op)
    );

    // The back end executes one operation per cycle whenever its output
    // register is empty or is being emptied by a transfer in the same cycle.
    rbc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .head_op       (head_op),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .reply_valid   (reply_valid),
        .reply_kind    (reply_kind),
        .reply_value   (reply_value),
        .beeper_on     (beeper_on),
        .round_running (round_running)
    );

endmodule
